// ===== rtl/rect_sad_trial_fill_defines.svh =====
// Assertion helpers used by the RTL of the rectangle trial block.
`ifndef RECT_SAD_TRIAL_FILL_DEFINES_SVH
`define RECT_SAD_TRIAL_FILL_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RSF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsf: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RSF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsf: next-cycle check failed");

`endif

// ===== rtl/rsf_pkg.sv =====
package rsf_pkg;

  // Default geometry.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_SIDE_DEF   = 64;
  localparam int PIX_DEF        = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int ADDR_W_DEF     = $clog2(PIX_DEF);
  localparam int SUM_W_DEF      = $clog2(765 * MAX_SIDE_DEF * MAX_SIDE_DEF + 1);

  // Fixed field widths.
  localparam int PIXEL_W   = 24;
  localparam int SUM_OUT_W = 22;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 1;

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TRIAL = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FILL,
    ST_RESP
  } state_t;

  // Controls from the sequencer to the SAD unit.
  typedef struct packed {
    logic clear;
    logic pix_vld;
  } sad_ctrl_t;

  // Status from the SAD unit back to the sequencer.
  typedef struct packed {
    logic busy;
  } sad_stat_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Sum of per-channel absolute differences of two RGB pixels.
  function automatic logic [9:0] pixel_sad(input logic [23:0] p, input logic [23:0] q);
    return 10'(absdiff8(p[23:16], q[23:16])) + 10'(absdiff8(p[15:8], q[15:8]))
         + 10'(absdiff8(p[7:0], q[7:0]));
  endfunction

endpackage

// ===== rtl/rsf_if.sv =====
// Trial, load and read command channel.
interface rsf_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [6:0]  rect_w;
  logic [6:0]  rect_h;
  logic [7:0]  colour_r;
  logic [7:0]  colour_g;
  logic [7:0]  colour_b;
  logic [23:0] pixel_rgb;

  modport source(output valid, command, pos_x, pos_y, rect_w, rect_h, colour_r, colour_g,
                 colour_b, pixel_rgb, input ready);
  modport sink(input valid, command, pos_x, pos_y, rect_w, rect_h, colour_r, colour_g,
               colour_b, pixel_rgb, output ready);
endinterface

// Result channel, one transaction per command.
interface rsf_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        bad_rect;
  logic [21:0] trial_sum;
  logic [21:0] current_sum;
  logic [23:0] read_rgb;

  modport source(output valid, accepted, bad_rect, trial_sum, current_sum, read_rgb,
                 input ready);
  modport sink(input valid, accepted, bad_rect, trial_sum, current_sum, read_rgb,
               output ready);
endinterface

// Register write channel.
interface rsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [8:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/rect_sad_trial_fill.sv =====
// A load, a rejected trial or the unused command goes from EXEC to RESP; a read
// passes READ_WAIT; a trial scans, drains and decides, then paints only when it wins.
// The canvas RAM has separate read and write ports; the drain lets the read and SAD stages empty.
// One command at a time; the next transaction can be taken in the cycle after the previous
// result is registered, even while that result waits.
// Synchronous reset sets both sizes to 256, then blacks all MAX_WIDTH*MAX_HEIGHT canvas pixels.
`include "rect_sad_trial_fill_defines.svh"

module rect_sad_trial_fill #(
  parameter int MAX_WIDTH  = rsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rsf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_SIDE   = rsf_pkg::MAX_SIDE_DEF
) (
  input logic           clk,
  input logic           rst,
  rsf_cfg_if.sink       cfg,
  rsf_item_if.sink      item,
  rsf_result_if.source  result
);

  localparam int PIX   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(PIX);
  localparam int CNT_W = $clog2(MAX_SIDE);
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam int SUM_W = $clog2(765 * MAX_SIDE * MAX_SIDE + 1);

  rsf_pkg::state_t    state, state_next;
  rsf_pkg::sad_ctrl_t sad_ctrl;
  rsf_pkg::sad_stat_t sad_stat;

  logic [8:0]       image_width, image_height;
  logic [8:0]       ew, eh;
  logic             item_fire;
  logic             in_bad;
  logic [AW-1:0]    in_start;

  logic [1:0]       cmd;
  logic [6:0]       rect_w, rect_h;
  logic [23:0]      colour, pixel;
  logic             bad;
  logic [AW-1:0]    start_addr, row_base, addr;
  logic [CNT_W-1:0] col, row;
  logic             last_col, last_row, last_clear;
  logic             rd_vld;
  logic             accepted;
  logic [23:0]      rd_rgb;
  logic             win;
  logic             result_load;

  logic             src_we, src_re, canvas_we, canvas_re;
  logic [23:0]      canvas_wdata, src_rdata, canvas_rdata;
  logic [SUM_W-1:0] tsum, csum;

  // Size registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rsf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        rsf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Usable extent, limited to the memory geometry.
  assign ew = (32'(image_width) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : image_width;
  assign eh = (32'(image_height) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : image_height;

  // Range check and start address of an incoming command.
  always_comb begin
    case (item.command)
      rsf_pkg::CMD_LOAD, rsf_pkg::CMD_READ: begin
        in_bad = ({1'b0, item.pos_x} >= ew) || ({1'b0, item.pos_y} >= eh);
      end
      rsf_pkg::CMD_TRIAL: begin
        in_bad = (item.rect_w == 7'd0) || (item.rect_h == 7'd0)
              || (32'(item.rect_w) > 32'(MAX_SIDE)) || (32'(item.rect_h) > 32'(MAX_SIDE))
              || (10'(item.pos_x) + 10'(item.rect_w) > 10'(ew))
              || (10'(item.pos_y) + 10'(item.rect_h) > 10'(eh));
      end
      default: in_bad = 1'b0;
    endcase
  end

  assign in_start  = AW'(item.pos_y) * AW'(MAX_WIDTH) + AW'(item.pos_x);
  assign item.ready = (state == rsf_pkg::ST_IDLE);
  assign item_fire  = item.valid && item.ready;

  assign last_col   = (CMP_W'(col) == CMP_W'(rect_w) - CMP_W'(1));
  assign last_row   = (CMP_W'(row) == CMP_W'(rect_h) - CMP_W'(1));
  assign last_clear = (addr == AW'(PIX - 1));
  assign win        = (tsum < csum);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rsf_pkg::ST_CLEAR:     if (last_clear) state_next = rsf_pkg::ST_IDLE;
      rsf_pkg::ST_IDLE:      if (item_fire) state_next = rsf_pkg::ST_EXEC;
      rsf_pkg::ST_EXEC: begin
        case (cmd)
          rsf_pkg::CMD_TRIAL: state_next = bad ? rsf_pkg::ST_RESP : rsf_pkg::ST_SCAN;
          rsf_pkg::CMD_READ:  state_next = bad ? rsf_pkg::ST_RESP : rsf_pkg::ST_READ_WAIT;
          default:            state_next = rsf_pkg::ST_RESP;
        endcase
      end
      rsf_pkg::ST_READ_WAIT: state_next = rsf_pkg::ST_RESP;
      rsf_pkg::ST_SCAN:      if (last_col && last_row) state_next = rsf_pkg::ST_DRAIN;
      rsf_pkg::ST_DRAIN:     if (!rd_vld && !sad_stat.busy) state_next = rsf_pkg::ST_DECIDE;
      rsf_pkg::ST_DECIDE:    state_next = win ? rsf_pkg::ST_FILL : rsf_pkg::ST_RESP;
      rsf_pkg::ST_FILL:      if (last_col && last_row) state_next = rsf_pkg::ST_RESP;
      rsf_pkg::ST_RESP:      if (!result.valid || result.ready) state_next = rsf_pkg::ST_IDLE;
      default:               state_next = rsf_pkg::ST_IDLE;
    endcase
  end

  // Memory strobes and unit controls.
  always_comb begin
    src_we           = 1'b0;
    src_re           = 1'b0;
    canvas_we        = 1'b0;
    canvas_re        = 1'b0;
    canvas_wdata     = '0;
    sad_ctrl.clear   = 1'b0;
    sad_ctrl.pix_vld = rd_vld;
    result_load      = 1'b0;
    case (state)
      rsf_pkg::ST_CLEAR: canvas_we = 1'b1;
      rsf_pkg::ST_EXEC: begin
        src_we         = (cmd == rsf_pkg::CMD_LOAD) && !bad;
        canvas_re      = (cmd == rsf_pkg::CMD_READ) && !bad;
        sad_ctrl.clear = (cmd == rsf_pkg::CMD_TRIAL);
      end
      rsf_pkg::ST_SCAN: begin
        src_re    = 1'b1;
        canvas_re = 1'b1;
      end
      rsf_pkg::ST_FILL: begin
        canvas_we    = 1'b1;
        canvas_wdata = colour;
      end
      rsf_pkg::ST_RESP: result_load = !result.valid || result.ready;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rsf_pkg::ST_CLEAR;
      addr         <= '0;
      rd_vld       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == rsf_pkg::ST_SCAN);
      if (result_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        rsf_pkg::ST_CLEAR: addr <= addr + AW'(1);
        rsf_pkg::ST_IDLE: begin
          if (item_fire) begin
            addr <= in_start;
          end
        end
        rsf_pkg::ST_SCAN, rsf_pkg::ST_FILL: begin
          if (last_col) begin
            addr <= row_base + AW'(MAX_WIDTH);
          end else begin
            addr <= addr + AW'(1);
          end
        end
        rsf_pkg::ST_DECIDE: addr <= start_addr;
        default: ;
      endcase
    end
  end

  // Command fields, rectangle walk and result data.
  always_ff @(posedge clk) begin
    case (state)
      rsf_pkg::ST_IDLE: begin
        if (item_fire) begin
          cmd        <= item.command;
          rect_w     <= item.rect_w;
          rect_h     <= item.rect_h;
          colour     <= {item.colour_r, item.colour_g, item.colour_b};
          pixel      <= item.pixel_rgb;
          bad        <= in_bad;
          start_addr <= in_start;
          row_base   <= in_start;
          col        <= '0;
          row        <= '0;
          accepted   <= 1'b0;
          rd_rgb     <= '0;
        end
      end
      rsf_pkg::ST_READ_WAIT: rd_rgb <= canvas_rdata;
      rsf_pkg::ST_SCAN, rsf_pkg::ST_FILL: begin
        if (last_col) begin
          col      <= '0;
          row      <= row + CNT_W'(1);
          row_base <= row_base + AW'(MAX_WIDTH);
        end else begin
          col <= col + CNT_W'(1);
        end
      end
      rsf_pkg::ST_DECIDE: begin
        accepted <= win;
        row_base <= start_addr;
        col      <= '0;
        row      <= '0;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (result_load) begin
      result.accepted <= accepted;
      result.bad_rect <= bad;
      result.read_rgb <= rd_rgb;
      if (cmd == rsf_pkg::CMD_TRIAL && !bad) begin
        result.trial_sum   <= rsf_pkg::SUM_OUT_W'(tsum);
        result.current_sum <= rsf_pkg::SUM_OUT_W'(csum);
      end else begin
        result.trial_sum   <= '0;
        result.current_sum <= '0;
      end
    end
  end

  // Source image memory.
  rsf_ram #(
    .DATA_W (rsf_pkg::PIXEL_W),
    .ADDR_W (AW),
    .DEPTH  (PIX)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (addr),
    .wdata (pixel),
    .re    (src_re),
    .raddr (addr),
    .rdata (src_rdata)
  );

  // Canvas memory.
  rsf_ram #(
    .DATA_W (rsf_pkg::PIXEL_W),
    .ADDR_W (AW),
    .DEPTH  (PIX)
  ) u_canvas_ram (
    .clk   (clk),
    .we    (canvas_we),
    .waddr (addr),
    .wdata (canvas_wdata),
    .re    (canvas_re),
    .raddr (addr),
    .rdata (canvas_rdata)
  );

  // Difference accumulators.
  rsf_sad #(
    .SUM_W (SUM_W)
  ) u_sad (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sad_ctrl),
    .src_pix    (src_rdata),
    .canvas_pix (canvas_rdata),
    .colour     (colour),
    .stat       (sad_stat),
    .tsum       (tsum),
    .csum       (csum)
  );

  // The canvas is painted only when the trial colour fits better.
  `RSF_ASSERT_IMP(a_fill_on_win, clk, rst, state == rsf_pkg::ST_FILL, tsum < csum)
  // The decision sees the sums only after the read pipeline has emptied.
  `RSF_ASSERT_IMP(a_decide_drained, clk, rst, state == rsf_pkg::ST_DECIDE,
                  !rd_vld && !sad_stat.busy)
  // The canvas port never reads and writes in the same cycle.
  `RSF_ASSERT_IMP(a_canvas_excl, clk, rst, canvas_we, !canvas_re)
  // An accepted transaction always starts execution next.
  `RSF_ASSERT_NXT(a_accept_exec, clk, rst, item.valid && item.ready,
                  state == rsf_pkg::ST_EXEC)

endmodule

// ===== rtl/rsf_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module rsf_ram #(
  parameter int DATA_W = rsf_pkg::PIXEL_W,
  parameter int ADDR_W = rsf_pkg::ADDR_W_DEF,
  parameter int DEPTH  = rsf_pkg::PIX_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered and held while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rsf_sad.sv =====
// Two SAD accumulators fed by one source pixel per cycle while pix_vld is high.
module rsf_sad #(
  parameter int SUM_W = rsf_pkg::SUM_W_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rsf_pkg::sad_ctrl_t  ctrl,
  input  logic [23:0]         src_pix,
  input  logic [23:0]         canvas_pix,
  input  logic [23:0]         colour,
  output rsf_pkg::sad_stat_t  stat,
  output logic [SUM_W-1:0]    tsum,
  output logic [SUM_W-1:0]    csum
);

  logic       sad_vld;
  logic [9:0] t_pix;
  logic [9:0] c_pix;

  // Stage valid for the per-pixel differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      sad_vld <= 1'b0;
    end else begin
      sad_vld <= ctrl.pix_vld;
    end
  end

  // Per-pixel SAD against the trial colour and against the canvas.
  always_ff @(posedge clk) begin
    t_pix <= rsf_pkg::pixel_sad(src_pix, colour);
    c_pix <= rsf_pkg::pixel_sad(src_pix, canvas_pix);
  end

  // Accumulate over the rectangle; cleared at the start of each trial.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      tsum <= '0;
      csum <= '0;
    end else if (sad_vld) begin
      tsum <= tsum + SUM_W'(t_pix);
      csum <= csum + SUM_W'(c_pix);
    end
  end

  assign stat.busy = sad_vld;

endmodule
